// ----- rtl/core/pwmt_pkg.sv -----
`default_nettype none

package pwmt_pkg;

    // Command codes carried in the opcode field
    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_PLAY        = 3'd1,
        OP_PLAY_ALT    = 3'd2,
        OP_PLAY_CUSTOM = 3'd3,
        OP_STOP        = 3'd4,
        OP_SET_CUSTOM  = 3'd5
    } opcode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_INDEX    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY_INDEX = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_ACTIVE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THEFT_ALARM     = 2'd3;

    // Level tables
    localparam int VOL_ENTRIES  = 5;
    localparam int FREQ_ENTRIES = 7;
    localparam logic [7:0] VOL_LEVELS [VOL_ENTRIES] = '{8'd15, 8'd30, 8'd60, 8'd80, 8'd90};
    localparam logic [7:0] PERIOD_LEVELS [FREQ_ENTRIES] =
        '{8'd90, 8'd110, 8'd140, 8'd160, 8'd180, 8'd200, 8'd250};

    // High time (period/2)*volume/100 for every table pair, modulo 256
    localparam logic [7:0] WIDTH_TABLE [FREQ_ENTRIES][VOL_ENTRIES] = '{
        '{8'd6,  8'd13, 8'd27, 8'd36,  8'd40},
        '{8'd8,  8'd16, 8'd33, 8'd44,  8'd49},
        '{8'd10, 8'd21, 8'd42, 8'd56,  8'd63},
        '{8'd12, 8'd24, 8'd48, 8'd64,  8'd72},
        '{8'd13, 8'd27, 8'd54, 8'd72,  8'd81},
        '{8'd15, 8'd30, 8'd60, 8'd80,  8'd90},
        '{8'd18, 8'd37, 8'd75, 8'd100, 8'd112}
    };

    // Reset state of the timer
    localparam logic [7:0] RESET_COMPARE_HIGH = 8'd1;
    localparam logic [7:0] RESET_COMPARE_LOW  = 8'd2;
    localparam logic [7:0] RESET_PERIOD       = 8'd100;
    localparam logic [7:0] RESET_VOLUME       = 8'd90;
    localparam logic [7:0] RESET_WIDTH        = 8'd45;

    // Reciprocal multipliers: x/50 and x/100, exact for 15-bit x
    localparam int          DUR_SHIFT = 21;
    localparam logic [15:0] DUR_RECIP = 16'd41944;
    localparam int          PCT_SHIFT = 21;
    localparam logic [14:0] PCT_RECIP = 15'd20972;
    localparam logic [7:0]  DUR_MAX   = 8'd255;

    // Command word
    typedef struct packed {
        logic [2:0]  opcode;
        logic [14:0] length;
        logic [7:0]  custom_volume;
        logic [7:0]  custom_period;
    } cmd_t;

    // Status word
    typedef struct packed {
        logic       speaker_pin;
        logic       running;
        logic       accepted;
        logic [7:0] duration_units;
        logic [7:0] tone_period;
        logic [7:0] tone_volume;
    } status_t;

    // Command after the front stages
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] duration;
        logic [7:0] custom_width;
        logic [7:0] custom_volume;
        logic [7:0] custom_period;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwmt_cmd_if.sv -----
`default_nettype none

interface pwmt_cmd_if
    import pwmt_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwmt_status_if.sv -----
`default_nettype none

interface pwmt_status_if
    import pwmt_pkg::*;
;
    logic    valid;
    logic    ready;
    status_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwmt_front.sv -----
`default_nettype none

module pwmt_front
    import pwmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire cmd_t  in_data,
    output logic       item_valid,
    input  wire logic  item_ready,
    output item_t      item_data
);

    // Stage A: products from the raw command
    logic        a_valid_reg;
    logic [2:0]  a_opcode_reg;
    logic [9:0]  a_dur_reg;
    logic [14:0] a_prod_reg;
    logic [7:0]  a_cvol_reg;
    logic [7:0]  a_cper_reg;
    logic [30:0] dur_prod;
    logic [14:0] width_prod;

    // Stage B: scaled width and saturated duration
    logic        b_valid_reg;
    item_t       b_data_reg;
    logic [29:0] pct_prod;
    logic [7:0]  dur_sat;
    logic        a_ready;
    logic        b_ready;

    // Stall a stage only when it holds a word that cannot move on
    assign b_ready  = !b_valid_reg || item_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // length/50 by reciprocal, (period/2)*volume
    assign dur_prod   = 31'(in_data.length) * 31'(DUR_RECIP);
    assign width_prod = 15'(in_data.custom_period[7:1]) * 15'(in_data.custom_volume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_opcode_reg <= in_data.opcode;
            a_dur_reg    <= dur_prod[DUR_SHIFT +: 10];
            a_prod_reg   <= width_prod;
            a_cvol_reg   <= in_data.custom_volume;
            a_cper_reg   <= in_data.custom_period;
        end
    end

    // Divide the product by 100, keep it modulo 256; clamp duration
    assign pct_prod = 30'(a_prod_reg) * 30'(PCT_RECIP);
    assign dur_sat  = (a_dur_reg > 10'(DUR_MAX)) ? DUR_MAX : a_dur_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg.opcode        <= a_opcode_reg;
            b_data_reg.duration      <= dur_sat;
            b_data_reg.custom_width  <= pct_prod[PCT_SHIFT +: 8];
            b_data_reg.custom_volume <= a_cvol_reg;
            b_data_reg.custom_period <= a_cper_reg;
        end
    end

    assign item_valid = b_valid_reg;
    assign item_data  = b_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pwm_tone_generator.sv -----
// Speaker tone generator on an 8-bit output-compare timer.
// cmd channel: one word per command (tick, play, play alt, play custom,
// stop, set custom). status channel: one word per command, giving pin
// level, run flag, play-accepted flag, pending duration, period, volume.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 volume index, 1 frequency index, 2 silence, 3 theft alarm); write
// only while no command is in flight.
// Pipeline: a command passes two front stages (the multiplies for
// length/50 and for the custom pulse width) and the timer state stage,
// which also loads the status register.
// Throughput: one command per cycle while status is taken; the timer
// state updates once per command, so commands flow back to back.
// Reset: counter 0, compares 1 and 2, pin low, timer stopped, period 100,
// volume 90, no pending duration, all configuration registers 0.
// Stall: while status is held, stages fill one by one; cmd.ready drops only
// once every stage holds a word.
`default_nettype none

module pwm_tone_generator
    import pwmt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    pwmt_cmd_if.sink                    cmd,
    pwmt_status_if.source               status,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic signed [3:0] vol_idx_reg;
    logic [2:0]        freq_idx_reg;
    logic              silence_reg;
    logic              alarm_reg;

    // Timer state
    logic [7:0] cnt_reg,     cnt_next;
    logic [7:0] cmp_hi_reg,  cmp_hi_next;
    logic [7:0] cmp_lo_reg,  cmp_lo_next;
    logic       pin_reg,     pin_next;
    logic       en_reg,      en_next;
    logic [7:0] period_reg,  period_next;
    logic [7:0] volume_reg,  volume_next;
    logic [7:0] width_reg,   width_next;
    logic [7:0] pend_reg,    pend_next;
    logic       accepted;

    // Status register
    logic    out_valid_reg;
    status_t out_reg;

    // Front stages
    logic  item_valid;
    logic  item_ready;
    item_t item;
    logic  fire;

    // Table selection
    logic       muted;
    logic [2:0] freq_slot;
    logic [2:0] freq_sel;
    logic [2:0] vol_slot;
    logic       play_ok;
    logic [7:0] cnt_inc;
    logic       hit_hi;
    logic       hit_lo;

    pwmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .in_data    (cmd.data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item)
    );

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_idx_reg  <= 4'sd0;
            freq_idx_reg <= 3'd0;
            silence_reg  <= 1'b0;
            alarm_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_VOLUME_INDEX:    vol_idx_reg  <= $signed(cfg_data[3:0]);
                CFG_FREQUENCY_INDEX: freq_idx_reg <= cfg_data[2:0];
                CFG_SILENCE_ACTIVE:  silence_reg  <= cfg_data[0];
                CFG_THEFT_ALARM:     alarm_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Select table slots; out-of-range and muted indexes take the top entry
    assign muted     = (vol_idx_reg == -4'sd1);
    assign freq_slot = (freq_idx_reg == 3'd7) ? 3'(FREQ_ENTRIES - 1) : freq_idx_reg;
    assign vol_slot  = ($unsigned(vol_idx_reg) < 4'(VOL_ENTRIES)) ?
                       3'($unsigned(vol_idx_reg)) : 3'(VOL_ENTRIES - 1);
    assign play_ok   = !((silence_reg || muted) && !alarm_reg) && (pend_reg == 8'd0);

    always_comb
    begin
        if (item.opcode == OP_PLAY_ALT)
        begin
            freq_sel = (freq_slot == 3'd0) ? 3'd1 : freq_slot - 3'd1;
        end
        else
        begin
            freq_sel = freq_slot;
        end
    end

    // Compare matches against the incremented counter
    assign cnt_inc = cnt_reg + 8'd1;
    assign hit_hi  = (cnt_inc == cmp_hi_reg);
    assign hit_lo  = (cnt_inc == cmp_lo_reg);

    // Advance the timer state for one command
    always_comb
    begin
        cnt_next    = cnt_reg;
        cmp_hi_next = cmp_hi_reg;
        cmp_lo_next = cmp_lo_reg;
        pin_next    = pin_reg;
        en_next     = en_reg;
        period_next = period_reg;
        volume_next = volume_reg;
        width_next  = width_reg;
        pend_next   = pend_reg;
        accepted    = 1'b0;
        unique case (item.opcode)
            OP_TICK:
            begin
                if (en_reg)
                begin
                    cnt_next = cnt_inc;
                    if (hit_hi)
                    begin
                        cmp_lo_next = cmp_hi_reg + width_reg;
                        cmp_hi_next = cmp_hi_reg + period_reg;
                        pin_next    = 1'b1;
                    end
                    if (hit_lo)
                    begin
                        pin_next = 1'b0;
                    end
                end
            end
            OP_PLAY, OP_PLAY_ALT, OP_PLAY_CUSTOM:
            begin
                if (play_ok)
                begin
                    if (item.opcode != OP_PLAY_CUSTOM)
                    begin
                        period_next = PERIOD_LEVELS[freq_sel];
                        volume_next = VOL_LEVELS[vol_slot];
                        width_next  = WIDTH_TABLE[freq_sel][vol_slot];
                    end
                    en_next   = 1'b1;
                    pend_next = item.duration;
                    accepted  = 1'b1;
                end
            end
            OP_STOP:
            begin
                en_next     = 1'b0;
                pin_next    = 1'b0;
                cnt_next    = 8'd0;
                cmp_hi_next = RESET_COMPARE_HIGH;
                cmp_lo_next = RESET_COMPARE_LOW;
                pend_next   = 8'd0;
            end
            OP_SET_CUSTOM:
            begin
                volume_next = item.custom_volume;
                period_next = item.custom_period;
                width_next  = item.custom_width;
            end
            default:
            begin
            end
        endcase
    end

    // Move a word into the status register when it is free or being taken
    assign item_ready = !out_valid_reg || status.ready;
    assign fire       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 8'd0;
            cmp_hi_reg <= RESET_COMPARE_HIGH;
            cmp_lo_reg <= RESET_COMPARE_LOW;
            pin_reg    <= 1'b0;
            en_reg     <= 1'b0;
            period_reg <= RESET_PERIOD;
            volume_reg <= RESET_VOLUME;
            width_reg  <= RESET_WIDTH;
            pend_reg   <= 8'd0;
        end
        else if (fire)
        begin
            cnt_reg    <= cnt_next;
            cmp_hi_reg <= cmp_hi_next;
            cmp_lo_reg <= cmp_lo_next;
            pin_reg    <= pin_next;
            en_reg     <= en_next;
            period_reg <= period_next;
            volume_reg <= volume_next;
            width_reg  <= width_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.speaker_pin    <= pin_next;
            out_reg.running        <= en_next;
            out_reg.accepted       <= accepted;
            out_reg.duration_units <= pend_next;
            out_reg.tone_period    <= period_next;
            out_reg.tone_volume    <= volume_next;
        end
    end

    assign status.valid = out_valid_reg;
    assign status.data  = out_reg;

    // A high pin needs a running timer
    a_pin_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        pin_reg |-> en_reg)
        else $error("speaker pin high while timer stopped");

    // A stopped timer sits at its reset position
    a_idle_position: assert property (@(posedge clk) disable iff (!rst_n)
        !en_reg |-> (cnt_reg == 8'd0) && (cmp_hi_reg == RESET_COMPARE_HIGH)
                    && (cmp_lo_reg == RESET_COMPARE_LOW))
        else $error("stopped timer not at reset position");

    // A pending duration only exists while running
    a_pend_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 8'd0) |-> en_reg)
        else $error("pending duration with timer stopped");

    // An accepted play always reports a running timer
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.accepted) |-> out_reg.running)
        else $error("accepted play without running timer");

endmodule

`default_nettype wire

// ----- tb/pwm_tone_checker.sv -----
`default_nettype none

module pwm_tone_checker
    import pwmt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    pwmt_cmd_if                         cmd,
    pwmt_status_if                      status,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          outstanding,
    output int                          compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0]  VOL_MUTED   = 4'hF;
    localparam logic [14:0] LENGTH_UNIT = 15'd50;
    localparam logic [15:0] PERCENT     = 16'd100;

    // Register copies
    logic [3:0] vol_sel;
    logic [2:0] freq_sel;
    logic       quiet;
    logic       alarm;

    // Timer and tone state
    logic [7:0] tick_cnt;
    logic [7:0] cmp_high;
    logic [7:0] cmp_low;
    logic       pin;
    logic       run_en;
    logic [7:0] period_q;
    logic [7:0] volume_q;
    logic [7:0] dur_q;

    status_t status_due_q[$];
    int      err_cnt;
    int      words_checked;

    // Flag one field that differs from the predicted status word
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Advance the tone state by one command word and form its status word
    task automatic tone_step(input cmd_t w, output status_t s);
        logic [15:0] high_time;
        logic [14:0] units;
        logic [2:0]  slot;
        logic        hit_high;
        logic        hit_low;
        logic        took;
        took = 1'b0;
        case (w.opcode)
            OP_TICK:
            begin
                if (run_en)
                begin
                    // Count first, then match against the compares as they stood
                    tick_cnt = tick_cnt + 8'd1;
                    hit_high = (tick_cnt == cmp_high);
                    hit_low  = (tick_cnt == cmp_low);
                    if (hit_high)
                    begin
                        high_time = ({8'd0, period_q >> 1} * {8'd0, volume_q}) / PERCENT;
                        cmp_low   = cmp_high + high_time[7:0];
                        cmp_high  = cmp_high + period_q;
                        pin       = 1'b1;
                    end
                    // A low match wins when both compares hit
                    if (hit_low)
                        pin = 1'b0;
                end
            end
            OP_PLAY, OP_PLAY_ALT, OP_PLAY_CUSTOM:
            begin
                if (!((quiet || vol_sel == VOL_MUTED) && !alarm) && dur_q == 8'd0)
                begin
                    if (w.opcode != OP_PLAY_CUSTOM)
                    begin
                        slot = (freq_sel < 3'(FREQ_ENTRIES)) ? freq_sel : 3'(FREQ_ENTRIES - 1);
                        if (w.opcode == OP_PLAY_ALT)
                            slot = (slot == 3'd0) ? 3'd1 : slot - 3'd1;
                        period_q = PERIOD_LEVELS[slot];
                        // Muted and out-of-range selects take the top volume
                        volume_q = (vol_sel < 4'(VOL_ENTRIES)) ? VOL_LEVELS[vol_sel]
                                                               : VOL_LEVELS[VOL_ENTRIES-1];
                    end
                    units  = w.length / LENGTH_UNIT;
                    dur_q  = (units > 15'(DUR_MAX)) ? DUR_MAX : units[7:0];
                    run_en = 1'b1;
                    took   = 1'b1;
                end
            end
            OP_STOP:
            begin
                run_en   = 1'b0;
                pin      = 1'b0;
                tick_cnt = 8'd0;
                cmp_high = RESET_COMPARE_HIGH;
                cmp_low  = RESET_COMPARE_LOW;
                dur_q    = 8'd0;
            end
            OP_SET_CUSTOM:
            begin
                volume_q = w.custom_volume;
                period_q = w.custom_period;
            end
            default:
            begin
            end
        endcase
        s.speaker_pin    = pin;
        s.running        = run_en;
        s.accepted       = took;
        s.duration_units = dur_q;
        s.tone_period    = period_q;
        s.tone_volume    = volume_q;
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            vol_sel       = 4'd0;
            freq_sel      = 3'd0;
            quiet         = 1'b0;
            alarm         = 1'b0;
            tick_cnt      = 8'd0;
            cmp_high      = RESET_COMPARE_HIGH;
            cmp_low       = RESET_COMPARE_LOW;
            pin           = 1'b0;
            run_en        = 1'b0;
            period_q      = RESET_PERIOD;
            volume_q      = RESET_VOLUME;
            dur_q         = 8'd0;
            err_cnt       = 0;
            words_checked = 0;
            status_due_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end
        else
        begin
            // Compare a delivered status word with the oldest prediction
            if (status.valid && status.ready)
            begin
                got = status.data;
                if (status_due_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t ns: status word with none expected: expected nothing, actual %h",
                             $time, got);
                end
                else
                begin
                    want = status_due_q.pop_front();
                    words_checked++;
                    check_field("speaker_pin", want.speaker_pin, got.speaker_pin);
                    check_field("running", want.running, got.running);
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("duration_units", want.duration_units, got.duration_units);
                    check_field("tone_period", want.tone_period, got.tone_period);
                    check_field("tone_volume", want.tone_volume, got.tone_volume);
                end
            end
            // Track register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_VOLUME_INDEX:    vol_sel  = cfg_data[3:0];
                    CFG_FREQUENCY_INDEX: freq_sel = cfg_data[2:0];
                    CFG_SILENCE_ACTIVE:  quiet    = cfg_data[0];
                    CFG_THEFT_ALARM:     alarm    = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            // Predict the status word of each accepted command
            if (cmd.valid && cmd.ready)
            begin
                tone_step(cmd.data, want);
                status_due_q.push_back(want);
            end
            mismatches  <= err_cnt;
            outstanding <= status_due_q.size();
            compared    <= words_checked;
        end
    end
endmodule

`default_nettype wire

// ----- tb/pwm_tone_generator_tb.sv -----
`default_nettype none

module pwm_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pwmt_pkg::*;

    localparam int RANDOM_WORDS = 1850;
    localparam int PHASES       = 14;
    localparam int PHASE_WORDS  = RANDOM_WORDS / PHASES;
    localparam int CALM_FROM    = RANDOM_WORDS - 120;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 64;
    localparam int SETTLE_WAIT  = 4;
    localparam int DRAIN_WAIT   = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // Settings walked first: mute, alarm, silence and out-of-range selects
    localparam logic [3:0] FIXED_VOL   [8] = '{4'hF, 4'hF, 4'h0, 4'h4, 4'h7, 4'h8, 4'h5, 4'hE};
    localparam logic [2:0] FIXED_FREQ  [8] = '{3'd0, 3'd6, 3'd3, 3'd6, 3'd7, 3'd0, 3'd1, 3'd5};
    localparam logic       FIXED_QUIET [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam logic       FIXED_ALARM [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int compared;
    int words_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    int phase_end     = 0;
    bit calm          = 1'b0;
    bit hold_done     = 1'b0;

    pwmt_cmd_if    cmd_ch ();
    pwmt_status_if status_ch ();

    pwm_tone_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .status    (status_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwm_tone_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .status      (status_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hold reset low at start, then release it
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stop a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial
    begin : status_side
        status_ch.ready <= 1'b0;
        forever
        begin
            if (!hold_done && words_sent >= HOLD_AFTER)
            begin
                status_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                status_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                status_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic cmd_t cmd_word(input logic [2:0] op, input logic [14:0] len,
                                      input logic [7:0] vol, input logic [7:0] per);
        cmd_t w;
        w.opcode        = op;
        w.length        = len;
        w.custom_volume = vol;
        w.custom_period = per;
        return w;
    endfunction

    // Mostly sub-unit lengths so plays can repeat; some long and saturating
    function automatic logic [14:0] pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 15'($urandom_range(0, 49));
            6:                return 15'($urandom_range(50, 12799));
            7:                return 15'($urandom_range(12750, 32767));
            default:          return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic cmd_t noise_word();
        return cmd_word(3'($urandom_range(0, 7)), 15'($urandom_range(0, 32767)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Offer one word, with an optional idle gap ahead of it
    task automatic send_word(input cmd_t w);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        words_sent++;
        if (words_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    // Drop valid and wait for every status word to come back
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_settings(input logic [3:0] vol, input logic [2:0] freq,
                                  input logic quiet, input logic alarm);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_VOLUME_INDEX;
        cfg_data  <= vol;
        @(posedge clk);
        cfg_index <= CFG_FREQUENCY_INDEX;
        cfg_data  <= {1'b0, freq};
        @(posedge clk);
        cfg_index <= CFG_SILENCE_ACTIVE;
        cfg_data  <= {3'd0, quiet};
        @(posedge clk);
        cfg_index <= CFG_THEFT_ALARM;
        cfg_data  <= {3'd0, alarm};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Maybe stop, maybe load a custom tone, then play and run the timer with some noise
    task automatic tone_sequence();
        int ticks;
        logic [7:0] per;
        if ($urandom_range(0, 3) != 0)
            send_word(cmd_word(OP_STOP, pick_length(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255))));
        if ($urandom_range(0, 2) == 0)
        begin
            per = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40))
                                              : 8'($urandom_range(0, 255));
            send_word(cmd_word(OP_SET_CUSTOM, pick_length(), 8'($urandom_range(0, 255)), per));
        end
        send_word(cmd_word(3'($urandom_range(int'(OP_PLAY), int'(OP_PLAY_CUSTOM))),
                           pick_length(), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255))));
        ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 260) : $urandom_range(8, 50);
        repeat (ticks)
        begin
            // End the run of ticks with the phase
            if (words_sent >= phase_end)
                break;
            if ($urandom_range(0, 19) == 0)
                send_word(noise_word());
            else
                send_word(cmd_word(OP_TICK, 15'($urandom_range(0, 32767)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
    endtask

    // Stimulus and verdict
    initial
    begin : cmd_side
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Tick while stopped, unused opcodes
        send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(3'd6, 15'h7FFF, 8'hFF, 8'hFF));
        send_word(cmd_word(3'd7, 15'd0, 8'd0, 8'd0));
        // Play with a sub-unit length, rise at count 1, alt play, fall
        send_word(cmd_word(OP_PLAY, 15'd49, 8'd0, 8'd0));
        send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(OP_PLAY_ALT, 15'd0, 8'd0, 8'd0));
        repeat (6) send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        // Saturated duration, then a play refused while it is pending
        send_word(cmd_word(OP_PLAY, 15'h7FFF, 8'd0, 8'd0));
        send_word(cmd_word(OP_PLAY_CUSTOM, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(OP_STOP, 15'd0, 8'd0, 8'd0));
        // Period 2 at 200 percent: both compares match on the same count
        send_word(cmd_word(OP_SET_CUSTOM, 15'd0, 8'd200, 8'd2));
        send_word(cmd_word(OP_PLAY_CUSTOM, 15'd50, 8'd0, 8'd0));
        repeat (3) send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        // Largest custom tone, high time wraps past 255
        send_word(cmd_word(OP_STOP, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(OP_SET_CUSTOM, 15'd0, 8'hFF, 8'hFF));
        send_word(cmd_word(OP_PLAY_CUSTOM, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        // Zero custom tone
        send_word(cmd_word(OP_SET_CUSTOM, 15'd0, 8'd0, 8'd0));
        send_word(cmd_word(OP_TICK, 15'd0, 8'd0, 8'd0));
        settle();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 8)
                write_settings(FIXED_VOL[p], FIXED_FREQ[p], FIXED_QUIET[p], FIXED_ALARM[p]);
            else
                write_settings(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                               ($urandom_range(0, 3) == 0), ($urandom_range(0, 1) == 0));
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 6)) send_word(noise_word());
                else
                    tone_sequence();
            end
            settle();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d command words under %0d register settings, with a %0d-cycle hold.",
                 words_sent, settings_used, HOLD_CYCLES);
        $display("Checked %0d status words, %0d mismatches.", compared, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
